[hw/rtl/ugbl_pkg.sv]
// Shared types, codes and helpers for the uniform grid bilinear lookup.
// Used by ugbl_axis and uniform_grid_bilinear_lookup; depends on nothing.
package ugbl_pkg;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP_RECIP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP_RECIP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED    = 3'd5;

    localparam logic [31:0] RECIP_RESET = 32'd65536;
    localparam logic [6:0]  USED_RESET  = 7'd64;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         load_row;
        logic [5:0]         load_col;
        logic signed [31:0] load_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
        logic               batch_last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               x_out_of_range;
        logic               result_last;
    } t_out_item;

    // Per-stage load enables for the coordinate unit
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_axis_en;

    // Saturate a 50 bit signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] res;
        if (v[49:31] == {19{v[49]}}) begin
            res = v[31:0];
        end else if (v[49]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

[hw/rtl/ugbl_axis.sv]
// Coordinate to cell unit: offset, scale by reciprocal step, floor, clamp, fraction.
// Four register stages; depends on ugbl_pkg.
module ugbl_axis #(
    parameter int IW = 6
) (
    input  logic                i_clk,
    input  ugbl_pkg::t_axis_en  i_en,
    input  logic signed [31:0]  i_coord,
    input  logic signed [31:0]  i_origin,
    input  logic [31:0]         i_recip,
    input  logic [IW-1:0]       i_last_idx,
    output logic [IW-1:0]       o_idx,
    output logic signed [31:0]  o_frac,
    output logic                o_clamp
);

    logic signed [32:0] diff;
    logic [32:0]        diff_abs;
    logic [63:0]        prod;
    logic [47:0]        pos_mag;
    logic signed [48:0] pos;
    logic signed [32:0] idx_raw;
    logic               idx_lo;
    logic               idx_hi;
    logic signed [48:0] frac_hi;

    logic               r_neg2;
    logic [31:0]        r_mag2;
    logic               r_neg3;
    logic [63:0]        r_prod3;
    logic signed [48:0] r_pos4;
    logic [IW-1:0]      r_idx5;
    logic signed [48:0] r_fracw5;
    logic               r_clamp5;

    // |diff| never exceeds 2^32-1, so the magnitude fits 32 bits
    assign diff     = {i_coord[31], i_coord} - {i_origin[31], i_origin};
    assign diff_abs = diff[32] ? (33'd0 - diff) : diff;
    assign prod     = r_mag2 * i_recip;

    // Negative side rounds the magnitude up: -(m + c) == ~m + !c
    assign pos_mag = r_prod3[63:16];
    assign pos     = r_neg3 ? ({1'b1, ~pos_mag} + 49'(r_prod3[15:0] == 16'd0))
                            : {1'b0, pos_mag};

    assign idx_raw = r_pos4[48:16];
    assign idx_lo  = idx_raw[32];
    assign idx_hi  = !idx_lo && (idx_raw[31:0] > 32'(i_last_idx));
    assign frac_hi = r_pos4 - $signed(49'({i_last_idx, 16'h0000}));

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_neg2 <= diff[32];
            r_mag2 <= diff_abs[31:0];
        end
        if (i_en.s3) begin
            r_neg3  <= r_neg2;
            r_prod3 <= prod;
        end
        if (i_en.s4) begin
            r_pos4 <= pos;
        end
        if (i_en.s5) begin
            r_clamp5 <= idx_lo | idx_hi;
            if (idx_lo) begin
                r_idx5   <= '0;
                r_fracw5 <= r_pos4;
            end else if (idx_hi) begin
                r_idx5   <= i_last_idx;
                r_fracw5 <= frac_hi;
            end else begin
                r_idx5   <= idx_raw[IW-1:0];
                r_fracw5 <= $signed({33'd0, r_pos4[15:0]});
            end
        end
    end

    assign o_idx   = r_idx5;
    assign o_frac  = ugbl_pkg::sat32({r_fracw5[48], r_fracw5});
    assign o_clamp = r_clamp5;

endmodule

[hw/rtl/uniform_grid_bilinear_lookup.sv]
// Bilinear lookup on a uniform grid held in four parity banks; depends on ugbl_pkg, ugbl_axis.
// Throughput: one transaction per cycle while o_in_stall is low; loads and queries mix
// freely, with the four corner reads served by the row/column parity banks in the same cycle.
// Reset clears the stage valid bits and the configuration registers; the sample
// table is not cleared and reads as undefined until written.
module uniform_grid_bilinear_lookup #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ugbl_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ugbl_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [ugbl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_wdata
);

    localparam int NS  = 12;
    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int BR  = (MAX_ROWS + 1) / 2;
    localparam int BC  = (MAX_COLS + 1) / 2;
    localparam int BD  = BR * BC;
    localparam int AW  = (BD > 1) ? $clog2(BD) : 1;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
        logic               last;
    } t_ld;

    typedef struct packed {
        logic xo;
        logic last;
    } t_meta;

    // Configuration
    logic signed [31:0] r_x_origin;
    logic signed [31:0] r_y_origin;
    logic [31:0]        r_x_recip;
    logic [31:0]        r_y_recip;
    logic [6:0]         r_rows_used;
    logic [6:0]         r_cols_used;
    logic [RIW-1:0]     x_last;
    logic [CIW-1:0]     y_last;

    // Pipeline control
    logic [NS:1]        r_vld;
    logic [NS:1]        adv;
    logic [NS:1]        stage_vld_in;

    // Payload
    t_ld                r_ld [1:5];
    logic signed [31:0] r_qx1;
    logic signed [31:0] r_qy1;
    ugbl_pkg::t_axis_en axis_en;
    logic [RIW-1:0]     x_idx;
    logic [CIW-1:0]     y_idx;
    logic signed [31:0] x_frac;
    logic signed [31:0] y_frac;
    logic               x_clamp;
    logic               y_clamp;

    logic               wr_en;
    logic [1:0]         wr_bank;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr [4];
    logic [31:0]        bank_q [4];

    logic signed [31:0] r_fx6, r_fy6;
    logic               r_ix0_6, r_iy0_6;
    t_meta              r_meta [6:11];
    logic signed [31:0] f00, f01, f10, f11;
    logic signed [32:0] d0, d1;

    logic signed [31:0] r_f00_7, r_f10_7, r_fx7, r_fy7;
    logic signed [32:0] r_d0_7, r_d1_7;
    logic signed [64:0] p0, p1;

    logic signed [64:0] r_p0_8, r_p1_8;
    logic signed [31:0] r_f00_8, r_f10_8, r_fx8;
    logic signed [31:0] row0, row1;

    logic signed [31:0] r_r0_9, r_r1_9, r_fx9;
    logic signed [32:0] dr;

    logic signed [31:0] r_r0_10, r_fx10;
    logic signed [32:0] r_d_10;
    logic signed [64:0] pr;

    logic signed [31:0] r_r0_11;
    logic signed [64:0] r_p_11;

    ugbl_pkg::t_out_item r_out;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin  <= '0;
            r_y_origin  <= '0;
            r_x_recip   <= ugbl_pkg::RECIP_RESET;
            r_y_recip   <= ugbl_pkg::RECIP_RESET;
            r_rows_used <= ugbl_pkg::USED_RESET;
            r_cols_used <= ugbl_pkg::USED_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ugbl_pkg::REG_X_ORIGIN:     r_x_origin  <= i_cfg_wdata;
                ugbl_pkg::REG_Y_ORIGIN:     r_y_origin  <= i_cfg_wdata;
                ugbl_pkg::REG_X_STEP_RECIP: r_x_recip   <= i_cfg_wdata;
                ugbl_pkg::REG_Y_STEP_RECIP: r_y_recip   <= i_cfg_wdata;
                ugbl_pkg::REG_ROWS_USED:    r_rows_used <= i_cfg_wdata[6:0];
                ugbl_pkg::REG_COLS_USED:    r_cols_used <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Highest cell index: used count held to 2 .. MAX, minus two
    always_comb begin
        if (r_rows_used < 7'd2) begin
            x_last = '0;
        end else if (int'(r_rows_used) > MAX_ROWS) begin
            x_last = RIW'(MAX_ROWS - 2);
        end else begin
            x_last = RIW'(r_rows_used - 7'd2);
        end
        if (r_cols_used < 7'd2) begin
            y_last = '0;
        end else if (int'(r_cols_used) > MAX_COLS) begin
            y_last = CIW'(MAX_COLS - 2);
        end else begin
            y_last = CIW'(r_cols_used - 7'd2);
        end
    end

    // A stage may take new content if it or any stage after it is empty, or if the output is not stalled
    for (genvar k = 1; k <= NS; k++) begin : g_adv
        assign adv[k] = ~(&r_vld[NS:k]) | ~i_out_stall;
    end

    // Loads leave the pipe once written into the table
    always_comb begin
        stage_vld_in[1] = i_in_valid;
        for (int k = 2; k <= NS; k++) begin
            stage_vld_in[k] = r_vld[k-1];
        end
        stage_vld_in[6] = r_vld[5] & (r_ld[5].cmd == ugbl_pkg::CMD_QUERY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= stage_vld_in[k];
                end
            end
        end
    end

    assign o_in_stall  = ~adv[1];
    assign o_out_valid = r_vld[NS];
    assign o_out_data  = r_out;

    // Coordinate units, stages 2 to 5
    assign axis_en = '{s2: adv[2], s3: adv[3], s4: adv[4], s5: adv[5]};

    ugbl_axis #(.IW(RIW)) u_axis_x (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_coord    (r_qx1),
        .i_origin   (r_x_origin),
        .i_recip    (r_x_recip),
        .i_last_idx (x_last),
        .o_idx      (x_idx),
        .o_frac     (x_frac),
        .o_clamp    (x_clamp)
    );

    ugbl_axis #(.IW(CIW)) u_axis_y (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_coord    (r_qy1),
        .i_origin   (r_y_origin),
        .i_recip    (r_y_recip),
        .i_last_idx (y_last),
        .o_idx      (y_idx),
        .o_frac     (y_frac),
        .o_clamp    (y_clamp)
    );

    // Table access in stage 5: bank = {row parity, column parity}
    assign wr_en   = r_vld[5] & adv[6] & (r_ld[5].cmd == ugbl_pkg::CMD_LOAD)
                   & (int'(r_ld[5].row) < MAX_ROWS) & (int'(r_ld[5].col) < MAX_COLS);
    assign wr_bank = {r_ld[5].row[0], r_ld[5].col[0]};
    assign wr_addr = AW'(int'(r_ld[5].row >> 1) * BC + int'(r_ld[5].col >> 1));

    // Bank of parity p holds index i when i is odd and p even: half index steps up
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            rd_addr[b] = AW'((int'(x_idx >> 1) + int'(x_idx[0] & ~b[1])) * BC
                             + int'(y_idx >> 1) + int'(y_idx[0] & ~b[0]));
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [31:0] r_mem [BD];
        logic [31:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(b))) begin
                r_mem[wr_addr] <= r_ld[5].value;
            end
            if (adv[6]) begin
                r_rd <= r_mem[rd_addr[b]];
            end
        end

        assign bank_q[b] = r_rd;
    end

    // Stage 6: corner selection and differences along y
    assign f00 = bank_q[{r_ix0_6, r_iy0_6}];
    assign f01 = bank_q[{r_ix0_6, ~r_iy0_6}];
    assign f10 = bank_q[{~r_ix0_6, r_iy0_6}];
    assign f11 = bank_q[{~r_ix0_6, ~r_iy0_6}];
    assign d0  = {f01[31], f01} - {f00[31], f00};
    assign d1  = {f11[31], f11} - {f10[31], f10};

    // Stage 7: y products
    assign p0 = r_d0_7 * r_fy7;
    assign p1 = r_d1_7 * r_fy7;

    // Stage 8: row blends
    assign row0 = ugbl_pkg::sat32($signed({{18{r_f00_8[31]}}, r_f00_8})
                                + $signed({r_p0_8[64], r_p0_8[64:16]}));
    assign row1 = ugbl_pkg::sat32($signed({{18{r_f10_8[31]}}, r_f10_8})
                                + $signed({r_p1_8[64], r_p1_8[64:16]}));

    // Stage 9: difference along x; stage 10: x product
    assign dr = {r_r1_9[31], r_r1_9} - {r_r0_9[31], r_r0_9};
    assign pr = r_d_10 * r_fx10;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_ld[1] <= '{cmd:   i_in_data.cmd,
                         row:   i_in_data.load_row,
                         col:   i_in_data.load_col,
                         value: i_in_data.load_value,
                         last:  i_in_data.batch_last};
            r_qx1   <= i_in_data.query_x;
            r_qy1   <= i_in_data.query_y;
        end
        for (int k = 2; k <= 5; k++) begin
            if (adv[k]) begin
                r_ld[k] <= r_ld[k-1];
            end
        end
        if (adv[6]) begin
            r_fx6     <= x_frac;
            r_fy6     <= y_frac;
            r_ix0_6   <= x_idx[0];
            r_iy0_6   <= y_idx[0];
            r_meta[6] <= '{xo: x_clamp, last: r_ld[5].last};
        end
        for (int k = 7; k <= 11; k++) begin
            if (adv[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
        if (adv[7]) begin
            r_f00_7 <= f00;
            r_f10_7 <= f10;
            r_d0_7  <= d0;
            r_d1_7  <= d1;
            r_fx7   <= r_fx6;
            r_fy7   <= r_fy6;
        end
        if (adv[8]) begin
            r_p0_8  <= p0;
            r_p1_8  <= p1;
            r_f00_8 <= r_f00_7;
            r_f10_8 <= r_f10_7;
            r_fx8   <= r_fx7;
        end
        if (adv[9]) begin
            r_r0_9 <= row0;
            r_r1_9 <= row1;
            r_fx9  <= r_fx8;
        end
        if (adv[10]) begin
            r_r0_10 <= r_r0_9;
            r_d_10  <= dr;
            r_fx10  <= r_fx9;
        end
        if (adv[11]) begin
            r_r0_11 <= r_r0_10;
            r_p_11  <= pr;
        end
        if (adv[12]) begin
            r_out.interp_value   <= ugbl_pkg::sat32(
                                        $signed({{18{r_r0_11[31]}}, r_r0_11})
                                      + $signed({r_p_11[64], r_p_11[64:16]}));
            r_out.x_out_of_range <= r_meta[11].xo;
            r_out.result_last    <= r_meta[11].last;
        end
    end

endmodule
